// ----- hdl/windowed_interval_slot_scheduler_assert.svh -----
// Assertion helpers shared by the scheduler RTL.
`ifndef WINDOWED_INTERVAL_SLOT_SCHEDULER_ASSERT_SVH
`define WINDOWED_INTERVAL_SLOT_SCHEDULER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define WISS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every edge outside reset.
`define WISS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

// ----- hdl/wiss_pkg.sv -----
`timescale 1ns / 1ps

package wiss_pkg;

  localparam int MIN_W        = 11;
  localparam int IVL_W        = 7;
  localparam int MPD_DEFAULT  = 1440;
  localparam logic [IVL_W-1:0] INTERVAL_MIN = 7'd5;
  localparam logic [IVL_W-1:0] INTERVAL_MAX = 7'd120;
  localparam logic [IVL_W-1:0] INTERVAL_RST = 7'd5;

  // Remainder pipeline depth.
  localparam int REM_STAGES = 3;

  // Register map, word index.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_ACTIVE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_END     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_IVL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY    = 3'd4;

  // Per-request sideband carried alongside the remainder pipeline.
  typedef struct packed {
    logic             ok;
    logic             run;
    logic             ge_s;
    logic             le_e;
    logic             le_s;
    logic [MIN_W-1:0] now;
    logic [MIN_W-1:0] capped;
    logic [MIN_W-1:0] gap;
    logic [MIN_W:0]   now_plus;
  } wiss_side_t;

  // One restoring-division step, remainder only.
  function automatic logic [IVL_W-1:0] rem_step(input logic [IVL_W-1:0] rem,
                                                input logic             din,
                                                input logic [IVL_W-1:0] ivl);
    logic [IVL_W:0] trial;
    trial = {rem, din};
    if (trial >= {1'b0, ivl}) begin
      rem_step = IVL_W'(trial - {1'b0, ivl});
    end else begin
      rem_step = trial[IVL_W-1:0];
    end
  endfunction

endpackage

// ----- hdl/wiss_rem_pipe.sv -----
`timescale 1ns / 1ps
`include "windowed_interval_slot_scheduler_assert.svh"

// Pipelined remainder of dividend by interval, a few bits per stage.
module wiss_rem_pipe (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [wiss_pkg::IVL_W-1:0] ivl,
  input  logic                      vld_in,
  input  logic [wiss_pkg::MIN_W-1:0] div_in,
  input  wiss_pkg::wiss_side_t      side_in,
  output logic                      vld_out,
  output logic [wiss_pkg::IVL_W-1:0] rem_out,
  output wiss_pkg::wiss_side_t      side_out
);
  import wiss_pkg::*;

  localparam int BPS = (MIN_W + REM_STAGES - 1) / REM_STAGES;

  logic             stg_vld  [REM_STAGES];
  logic [IVL_W-1:0] stg_rem  [REM_STAGES];
  logic [MIN_W-1:0] stg_div  [REM_STAGES];
  wiss_side_t       stg_side [REM_STAGES];

  for (genvar k = 0; k < REM_STAGES; k++) begin : g_stg
    logic             v_in;
    logic [IVL_W-1:0] r_in;
    logic [MIN_W-1:0] d_in;
    wiss_side_t       s_in;
    logic [IVL_W-1:0] r_c;
    logic [MIN_W-1:0] d_c;

    if (k == 0) begin : g_head
      assign v_in = vld_in;
      assign r_in = '0;
      assign d_in = div_in;
      assign s_in = side_in;
    end else begin : g_body
      assign v_in = stg_vld[k-1];
      assign r_in = stg_rem[k-1];
      assign d_in = stg_div[k-1];
      assign s_in = stg_side[k-1];
    end

    always_comb begin
      r_c = r_in;
      d_c = d_in;
      for (int j = 0; j < BPS; j++) begin
        if (k * BPS + j < MIN_W) begin
          r_c = rem_step(r_c, d_c[MIN_W-1], ivl);
          d_c = {d_c[MIN_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_vld[k] <= 1'b0;
      end else begin
        stg_vld[k] <= v_in;
      end
      stg_rem[k]  <= r_c;
      stg_div[k]  <= d_c;
      stg_side[k] <= s_in;
    end
  end

  assign vld_out  = stg_vld[REM_STAGES-1];
  assign rem_out  = stg_rem[REM_STAGES-1];
  assign side_out = stg_side[REM_STAGES-1];

  `WISS_ASSERT_IMPL(a_rem_lt_ivl, clk, rst, vld_out && side_out.ok, rem_out < ivl,
                    "remainder not below interval")
  `WISS_ASSERT_IMPL(a_rem_latency, clk, rst, vld_out, $past(vld_in, REM_STAGES),
                    "remainder valid without matching request")

endmodule

// ----- hdl/windowed_interval_slot_scheduler.sv -----
`timescale 1ns / 1ps
`include "windowed_interval_slot_scheduler_assert.svh"

// Windowed interval slot scheduler. Each request (start high while busy is
// low) carries one minute-of-day value and yields exactly one result, shown
// for a single cycle with done high. The minute offset is reduced modulo
// the slot interval over three pipeline stages of four, four and three
// bits, with one stage of setup ahead and one output stage behind; done
// rises once a request has passed through all of them. A new request is
// taken every cycle; busy is only high during reset. The result cannot be
// held off by the receiver, so capture it when done is high.
// Registers (APB, word aligned): 0 day_active, 1 window_start, 2 window_end,
// 3 slot_interval, 4 recovery_window. Write them only while no request is in
// flight; the pipeline reads them live.
module windowed_interval_slot_scheduler #(
  parameter int MINUTES_PER_DAY = wiss_pkg::MPD_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  logic [wiss_pkg::MIN_W-1:0] minute_now,
  // result channel
  output logic                       done,
  output logic                       schedule_ok,
  output logic                       slot_due,
  output logic                       latest_found,
  output logic [wiss_pkg::MIN_W-1:0] latest_slot,
  output logic                       next_found,
  output logic [wiss_pkg::MIN_W-1:0] next_slot,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import wiss_pkg::*;

  // Day limit held one bit wider so 2048 still fits.
  localparam logic [MIN_W:0] DayLim = (MIN_W + 1)'(MINUTES_PER_DAY);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic             day_active;
  logic [MIN_W-1:0] window_start;
  logic [MIN_W-1:0] window_end;
  logic [IVL_W-1:0] slot_interval;
  logic [MIN_W-1:0] recovery_window;

  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      day_active      <= 1'b0;
      window_start    <= '0;
      window_end      <= '0;
      slot_interval   <= INTERVAL_RST;
      recovery_window <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DAY_ACTIVE: day_active      <= pwdata[0];
        REG_WIN_START:  window_start    <= pwdata[MIN_W-1:0];
        REG_WIN_END:    window_end      <= pwdata[MIN_W-1:0];
        REG_SLOT_IVL:   slot_interval   <= pwdata[IVL_W-1:0];
        REG_RECOVERY:   recovery_window <= pwdata[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DAY_ACTIVE: prdata = {31'd0, day_active};
      REG_WIN_START:  prdata = {{(32-MIN_W){1'b0}}, window_start};
      REG_WIN_END:    prdata = {{(32-MIN_W){1'b0}}, window_end};
      REG_SLOT_IVL:   prdata = {{(32-IVL_W){1'b0}}, slot_interval};
      REG_RECOVERY:   prdata = {{(32-MIN_W){1'b0}}, recovery_window};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage 1: compares, capped minute, offset into the window
  // ---------------------------------------------------------------------
  logic             req_acc;
  logic             sched_ok;
  wiss_side_t       side_c;
  logic [MIN_W-1:0] div_c;

  assign busy    = rst;
  assign req_acc = start && !busy;

  assign sched_ok = ({1'b0, window_start} < DayLim) &&
                    ({1'b0, window_end} < DayLim) &&
                    (window_end >= window_start) &&
                    (slot_interval >= INTERVAL_MIN) &&
                    (slot_interval <= INTERVAL_MAX);

  always_comb begin
    side_c.ok       = sched_ok;
    side_c.run      = sched_ok && day_active;
    side_c.ge_s     = minute_now >= window_start;
    side_c.le_e     = minute_now <= window_end;
    side_c.le_s     = minute_now <= window_start;
    side_c.now      = minute_now;
    side_c.capped   = (minute_now < window_end) ? minute_now : window_end;
    side_c.gap      = minute_now - side_c.capped;
    side_c.now_plus = {1'b0, minute_now} + {{(MIN_W+1-IVL_W){1'b0}}, slot_interval};
    // offset only meaningful once past the start
    div_c           = side_c.ge_s ? side_c.capped - window_start : '0;
  end

  logic             s1_vld;
  wiss_side_t       s1_side;
  logic [MIN_W-1:0] s1_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= req_acc;
    end
    s1_side <= side_c;
    s1_div  <= div_c;
  end

  // ---------------------------------------------------------------------
  // Stages 2..4: offset modulo slot interval
  // ---------------------------------------------------------------------
  logic             rp_vld;
  logic [IVL_W-1:0] rp_rem;
  wiss_side_t       rp_side;

  wiss_rem_pipe u_rem (
    .clk      (clk),
    .rst      (rst),
    .ivl      (slot_interval),
    .vld_in   (s1_vld),
    .div_in   (s1_div),
    .side_in  (s1_side),
    .vld_out  (rp_vld),
    .rem_out  (rp_rem),
    .side_out (rp_side)
  );

  // ---------------------------------------------------------------------
  // Stage 5: slot arithmetic and result register
  // ---------------------------------------------------------------------
  // latest = capped - rem; lateness = (now - capped) + rem
  // next   = start when now <= start, now when on a slot, else now + interval - rem
  logic [MIN_W-1:0] lat_c;
  logic [MIN_W:0]   late_c;
  logic [MIN_W:0]   nxt_c;
  logic             rem_zero;
  logic             due_c;
  logic             lfound_c;
  logic             nfound_c;

  always_comb begin
    rem_zero = rp_rem == '0;
    lat_c    = rp_side.capped - {{(MIN_W-IVL_W){1'b0}}, rp_rem};
    late_c   = {1'b0, rp_side.gap} + {{(MIN_W+1-IVL_W){1'b0}}, rp_rem};
    if (rp_side.le_s) begin
      nxt_c = {1'b0, window_start};
    end else if (rem_zero) begin
      nxt_c = {1'b0, rp_side.now};
    end else begin
      nxt_c = rp_side.now_plus - {{(MIN_W+1-IVL_W){1'b0}}, rp_rem};
    end
    due_c    = rp_side.run && rp_side.ge_s && rp_side.le_e && rem_zero;
    lfound_c = rp_side.run && rp_side.ge_s && (late_c <= {1'b0, recovery_window});
    nfound_c = rp_side.run && rp_side.le_e && (nxt_c <= {1'b0, window_end});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rp_vld;
    end
    if (rp_vld) begin
      schedule_ok  <= rp_side.ok;
      slot_due     <= due_c;
      latest_found <= lfound_c;
      latest_slot  <= lfound_c ? lat_c : '0;
      next_found   <= nfound_c;
      next_slot    <= nfound_c ? nxt_c[MIN_W-1:0] : '0;
    end
  end

  `WISS_ASSERT_IMPL(a_done_latency, clk, rst, done, $past(start && !busy, 5),
                    "result without a request five cycles back")
  `WISS_ASSERT_IMPL(a_due_consistent, clk, rst, done && slot_due,
                    latest_found && next_found && latest_slot == next_slot,
                    "due slot not reported as latest and next")
  `WISS_ASSERT_IMPL(a_slot_order, clk, rst, done && latest_found && next_found,
                    latest_slot <= next_slot, "latest slot after next slot")
  `WISS_ASSERT_ALWAYS(a_invalid_quiet, clk, rst,
                      !done || schedule_ok || (!slot_due && !latest_found && !next_found),
                      "slot reported on invalid schedule")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the windowed interval slot scheduler.
// The initial block builds a list of pending operations: minute requests,
// register writes and drain markers. A clocked driver works through that
// list, and a clocked monitor checks every result strobe against the oldest
// expected report.
module tb_top;
  import wiss_pkg::*;

  // Register indexes that are not decoded; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // Idle cycles required after the last result before a drain marker
  // clears. The pipeline is five deep, so this covers it with margin.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_REQUESTS = 600;

  typedef enum logic [1:0] {OP_QUERY, OP_WRITE, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t             kind;
    logic [MIN_W-1:0]     minute;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          data;
  } pend_op_t;

  typedef struct packed {
    logic             schedule_ok;
    logic             slot_due;
    logic             latest_found;
    logic [MIN_W-1:0] latest_slot;
    logic             next_found;
    logic [MIN_W-1:0] next_slot;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Block inputs, known from time zero.
  logic             start      = 1'b0;
  logic [MIN_W-1:0] minute_now = '0;
  logic             psel       = 1'b0;
  logic             penable    = 1'b0;
  logic             pwrite     = 1'b0;
  logic [4:0]       paddr      = '0;
  logic [31:0]      pwdata     = '0;

  // Block outputs.
  logic             busy;
  logic             done;
  logic             schedule_ok;
  logic             slot_due;
  logic             latest_found;
  logic [MIN_W-1:0] latest_slot;
  logic             next_found;
  logic [MIN_W-1:0] next_slot;
  logic [31:0]      prdata;
  logic             pready;

  // Shadow copy of the schedule registers, reset values included.
  logic             sched_active   = 1'b0;
  logic [MIN_W-1:0] sched_start    = '0;
  logic [MIN_W-1:0] sched_end      = '0;
  logic [IVL_W-1:0] sched_interval = INTERVAL_RST;
  logic [MIN_W-1:0] sched_recovery = '0;

  pend_op_t     pending_q[$];
  slot_report_t report_q[$];

  // issued_cnt is owned by the driver, checked_cnt by the monitor; both move
  // by nonblocking assignment so either side sees stable pre-edge values.
  int issued_cnt  = 0;
  int checked_cnt = 0;
  int fail_cnt    = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int settle_cnt  = 0;

  windowed_interval_slot_scheduler uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .minute_now   (minute_now),
    .done         (done),
    .schedule_ok  (schedule_ok),
    .slot_due     (slot_due),
    .latest_found (latest_found),
    .latest_slot  (latest_slot),
    .next_found   (next_found),
    .next_slot    (next_slot),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Expected report for one minute under the current shadow schedule.
  // Plain integer math: latest slot is the window start plus whole
  // intervals up to min(now, end); next slot rounds now up to the grid.
  function automatic slot_report_t predict_report(input logic [MIN_W-1:0] now_in);
    slot_report_t rep;
    int now, s, e, iv, capped, slot, upcoming, rem;
    bit run;
    now = now_in;
    s   = sched_start;
    e   = sched_end;
    iv  = sched_interval;
    rep = '0;
    rep.schedule_ok = (s < MPD_DEFAULT) && (e < MPD_DEFAULT) && (e >= s) &&
                      (iv >= INTERVAL_MIN) && (iv <= INTERVAL_MAX);
    run = rep.schedule_ok && sched_active;
    if (run) begin
      if (now >= s && now <= e && ((now - s) % iv) == 0) rep.slot_due = 1'b1;
      if (now >= s) begin
        capped = (now < e) ? now : e;
        slot   = s + ((capped - s) / iv) * iv;
        // a slot more than the recovery window behind is considered missed
        if (now - slot <= sched_recovery) begin
          rep.latest_found = 1'b1;
          rep.latest_slot  = slot[MIN_W-1:0];
        end
      end
      if (now <= e) begin
        if (now <= s) begin
          upcoming = s;
        end else begin
          rem      = (now - s) % iv;
          upcoming = (rem == 0) ? now : now + iv - rem;
        end
        if (upcoming <= e) begin
          rep.next_found = 1'b1;
          rep.next_slot  = upcoming[MIN_W-1:0];
        end
      end
    end
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: requests go out in bursts with random gaps; register writes use
  // a setup and an access cycle; a drain marker holds everything back until
  // all reports are in and the pipeline has had time to empty.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    pend_op_t op;
    int       took;
    logic     nxt_start, nxt_sel, nxt_en;
    if (rst) begin
      start      <= 1'b0;
      minute_now <= '0;
      psel       <= 1'b0;
      penable    <= 1'b0;
      pwrite     <= 1'b0;
      paddr      <= '0;
      pwdata     <= '0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
      settle_cnt = 0;
    end else begin
      took      = 0;
      nxt_start = start;
      nxt_sel   = psel;
      nxt_en    = penable;

      // request taken at this edge: predict it now, with the live schedule
      if (start && !busy) begin
        report_q.push_back(predict_report(minute_now));
        op        = pending_q.pop_front();
        took      = 1;
        nxt_start = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = $urandom_range(0, 9);
        end
      end

      // register write completes at the access edge
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_DAY_ACTIVE: sched_active   = pwdata[0];
          REG_WIN_START:  sched_start    = pwdata[MIN_W-1:0];
          REG_WIN_END:    sched_end      = pwdata[MIN_W-1:0];
          REG_SLOT_IVL:   sched_interval = pwdata[IVL_W-1:0];
          REG_RECOVERY:   sched_recovery = pwdata[MIN_W-1:0];
          default: ;
        endcase
        op      = pending_q.pop_front();
        nxt_sel = 1'b0;
        nxt_en  = 1'b0;
      end else if (psel && !penable) begin
        nxt_en = 1'b1;
      end

      // nothing in flight: start the next pending operation
      if (!nxt_start && !nxt_sel && pending_q.size() != 0) begin
        op = pending_q[0];
        case (op.kind)
          OP_QUERY: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              nxt_start = 1'b1;
              minute_now <= op.minute;
            end
          end
          OP_WRITE: begin
            nxt_sel = 1'b1;
            nxt_en  = 1'b0;
            pwrite <= 1'b1;
            paddr  <= {op.reg_idx, 2'b00};
            pwdata <= op.data;
          end
          OP_DRAIN: begin
            if (issued_cnt + took != checked_cnt) begin
              settle_cnt = 0;
            end else if (settle_cnt < SETTLE_CYCLES) begin
              settle_cnt++;
            end else begin
              settle_cnt = 0;
              op = pending_q.pop_front();
            end
          end
          default: ;
        endcase
      end

      start      <= nxt_start;
      psel       <= nxt_sel;
      penable    <= nxt_en;
      issued_cnt <= issued_cnt + took;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: done cannot be stalled, so every strobe is checked at once.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    slot_report_t want;
    if (!rst && done) begin
      if (checked_cnt >= issued_cnt) begin
        $error("report strobe with no request outstanding");
        fail_cnt++;
      end else begin
        want = report_q.pop_front();
        check_field("schedule_ok", 32'(want.schedule_ok), 32'(schedule_ok));
        check_field("slot_due", 32'(want.slot_due), 32'(slot_due));
        check_field("latest_found", 32'(want.latest_found), 32'(latest_found));
        check_field("latest_slot", 32'(want.latest_slot), 32'(latest_slot));
        check_field("next_found", 32'(want.next_found), 32'(next_found));
        check_field("next_slot", 32'(want.next_slot), 32'(next_slot));
        checked_cnt <= checked_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Operation list helpers. Writes made by set_schedule carry random junk above
  // the register width; the block must drop it.
  // ---------------------------------------------------------------------
  function automatic void add_query(input int m);
    pend_op_t op;
    op.kind    = OP_QUERY;
    op.minute  = m[MIN_W-1:0];
    op.reg_idx = '0;
    op.data    = '0;
    pending_q.push_back(op);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [31:0] value, input logic [31:0] keep);
    pend_op_t op;
    op.kind    = OP_WRITE;
    op.minute  = '0;
    op.reg_idx = idx;
    op.data    = ($urandom() & ~keep) | (value & keep);
    pending_q.push_back(op);
  endfunction

  function automatic void add_drain();
    pend_op_t op;
    op.kind    = OP_DRAIN;
    op.minute  = '0;
    op.reg_idx = '0;
    op.data    = '0;
    pending_q.push_back(op);
  endfunction

  // Wait for idle, then rewrite the whole schedule.
  function automatic void set_schedule(input int act, input int s, input int e,
                                       input int iv, input int rec);
    add_drain();
    add_write(REG_DAY_ACTIVE, act, 32'h1);
    add_write(REG_WIN_START, s, 32'h7FF);
    add_write(REG_WIN_END, e, 32'h7FF);
    add_write(REG_SLOT_IVL, iv, 32'h7F);
    add_write(REG_RECOVERY, rec, 32'h7FF);
  endfunction

  initial begin : run_test
    int n_req, phase_len, pick, act, s, e, iv, rec, lo, hi, step, m;

    // reset schedule: valid but inactive, so only schedule_ok is set
    add_query(0);
    add_query(2047);

    // regular window, small recovery; undecoded writes must not disturb it
    set_schedule(1, 100, 400, 30, 10);
    add_write(REG_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_write(REG_SPARE_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_query(0);
    add_query(99);
    add_query(100);
    add_query(101);
    add_query(115);
    add_query(130);
    add_query(395);
    add_query(400);
    add_query(401);
    add_query(410);
    add_query(411);
    add_query(1439);
    add_query(2047);   // minute beyond the day, used as is

    // widest interval over the whole day, recovery at its maximum
    set_schedule(1, 0, 1439, 120, 2047);
    add_query(0);
    add_query(1439);
    add_query(2047);
    add_query(1201);

    // invalid schedules: everything but schedule_ok must stay low
    set_schedule(1, 500, 499, 10, 5);    // end before start
    add_query(500);
    set_schedule(1, 2047, 2047, 5, 0);   // start and end past the day
    add_query(2047);
    set_schedule(1, 1439, 1440, 5, 0);   // end one past the day
    add_query(1439);
    set_schedule(1, 0, 100, 4, 0);       // interval just too short
    add_query(0);
    set_schedule(1, 0, 100, 121, 0);     // interval just too long
    add_query(0);
    set_schedule(1, 0, 100, 0, 0);       // zero interval
    add_query(50);

    // random phases: mostly valid, active schedules with queries aimed at
    // the window, its slot grid and the recovery span
    n_req = 0;
    while (n_req < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      act  = (pick < 10) ? 0 : 1;
      if (pick < 80) begin
        s = $urandom_range(0, 1439);
        e = $urandom_range(s, 1439);
        case ($urandom_range(0, 5))
          0: s = 0;
          1: e = 1439;
          2: e = s;
          default: ;
        endcase
        case ($urandom_range(0, 4))
          0: iv = INTERVAL_MIN;
          1: iv = INTERVAL_MAX;
          default: iv = $urandom_range(INTERVAL_MIN, INTERVAL_MAX);
        endcase
      end else begin
        s  = $urandom_range(0, 2047);
        e  = $urandom_range(0, 2047);
        iv = $urandom_range(0, 127);
      end
      case ($urandom_range(0, 3))
        0: rec = 0;
        1: rec = $urandom_range(0, 3 * ((iv < 5) ? 5 : iv));
        2: rec = $urandom_range(0, 2047);
        default: rec = 2047;
      endcase
      set_schedule(act, s, e, iv, rec);

      step = (iv < 5) ? 5 : iv;
      lo   = (s > 20) ? s - 20 : 0;
      hi   = e + rec + 20;
      if (hi > 2047) hi = 2047;
      if (hi < lo) hi = 2047;
      phase_len = $urandom_range(10, 50);
      repeat (phase_len) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          m = $urandom_range(0, 2047);
        end else if (pick < 5) begin
          // on the slot grid or one minute to either side of it
          m = s + step * $urandom_range(0, (e >= s) ? (e - s) / step + 1 : 2)
              + $urandom_range(0, 2) - 1;
        end else begin
          m = $urandom_range(lo, hi);
        end
        if (m < 0) m = 0;
        if (m > 2047) m = 2047;
        add_query(m);
        n_req++;
      end
    end
    add_drain();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
    if (issued_cnt != checked_cnt) begin
      $error("%0d reports never arrived", issued_cnt - checked_cnt);
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("windowed_interval_slot_scheduler test passed");
    end else begin
      $display("windowed_interval_slot_scheduler test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("windowed_interval_slot_scheduler test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/wiss_pkg.sv
hdl/wiss_rem_pipe.sv
hdl/windowed_interval_slot_scheduler.sv
test/tb_top.sv
